[hdl/mvs_pkg.sv]
package mvs_pkg;

    localparam int MAX_VECTORS = 65536;
    localparam int COUNT_LIMIT = 65536;
    localparam int VEC_CAP     = (MAX_VECTORS < COUNT_LIMIT) ? MAX_VECTORS : COUNT_LIMIT;

    localparam int MAG_W   = 16;
    localparam int DIR_W   = 16;
    localparam int TALLY_W = 17;
    localparam int SUM_W   = 32;
    localparam int BIN_W   = 3;
    localparam int NUM_BINS = 8;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_STATIC_THR = 1'b0;
    localparam logic CFG_HIGH_THR   = 1'b1;

    localparam logic [MAG_W-1:0] STATIC_THR_RESET = 16'd16;
    localparam logic [MAG_W-1:0] HIGH_THR_RESET   = 16'd160;
    localparam logic [MAG_W-1:0] ONE_Q4           = 16'd16;

    // Bin edges on the Q3.13 code, rounded so that the integer compare
    // matches the exact compare with odd multiples of pi/8.
    localparam logic signed [DIR_W-1:0] EDGE_P1 = 16'sd3217;
    localparam logic signed [DIR_W-1:0] EDGE_P3 = 16'sd9651;
    localparam logic signed [DIR_W-1:0] EDGE_P5 = 16'sd16085;
    localparam logic signed [DIR_W-1:0] EDGE_P7 = 16'sd22519;
    localparam logic signed [DIR_W-1:0] EDGE_P9 = 16'sd28953;
    localparam logic signed [DIR_W-1:0] EDGE_N1 = -16'sd3216;
    localparam logic signed [DIR_W-1:0] EDGE_N3 = -16'sd9650;
    localparam logic signed [DIR_W-1:0] EDGE_N5 = -16'sd16084;
    localparam logic signed [DIR_W-1:0] EDGE_N7 = -16'sd22518;
    localparam logic signed [DIR_W-1:0] EDGE_N9 = -16'sd28952;

    typedef logic [BIN_W-1:0] bin_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        bin_t             bin;
        logic             is_static;
        logic             is_high;
        logic             is_moving;
        logic             carries;
        logic             closes;
    } mvs_entry_t;

    typedef struct packed {
        logic       valid;
        mvs_entry_t entry;
    } mvs_word_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } back_state_t;

    function automatic bin_t pick_bin(input logic signed [DIR_W-1:0] a);
        bin_t b;
        if (a >= 0)
        begin
            if (a < EDGE_P1)      b = 3'd0;
            else if (a < EDGE_P3) b = 3'd1;
            else if (a < EDGE_P5) b = 3'd2;
            else if (a < EDGE_P7) b = 3'd3;
            else if (a < EDGE_P9) b = 3'd4;
            else                  b = 3'd5;
        end
        else
        begin
            if (a >= EDGE_N1)      b = 3'd0;
            else if (a >= EDGE_N3) b = 3'd7;
            else if (a >= EDGE_N5) b = 3'd6;
            else if (a >= EDGE_N7) b = 3'd5;
            else if (a >= EDGE_N9) b = 3'd4;
            else                   b = 3'd3;
        end
        return b;
    endfunction

endpackage

[hdl/mvs_div.sv]
module mvs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mvs_pkg::SUM_W-1:0]           dividend,
    input  logic [mvs_pkg::TALLY_W-1:0]         divisor,
    output logic                                done,
    output logic [mvs_pkg::MAG_W-1:0]           quotient
);
    import mvs_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]   quot_reg, quot_next;
    logic [TALLY_W-1:0] rem_reg, rem_next;
    logic [TALLY_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TALLY_W:0]   trial;
    logic               fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quot_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[SUM_W-2:0], fits};
            rem_next  = fits ? TALLY_W'(trial - {1'b0, dvs_reg}) : trial[TALLY_W-1:0];
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg[MAG_W-1:0];

endmodule

[hdl/mvs_fifo.sv]
module mvs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  mvs_pkg::mvs_word_t  push,
    output logic                full,
    output mvs_pkg::mvs_word_t  pop,
    input  logic                pop_ready
);
    import mvs_pkg::*;

    mvs_entry_t              mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_push, do_pop;

    assign full    = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign do_push = push.valid && !full;
    assign do_pop  = pop.valid && pop_ready;

    assign pop.valid = count_reg != '0;
    assign pop.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? FIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = FIFO_CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = FIFO_CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.entry;
    end

endmodule

[hdl/mvs_front.sv]
module mvs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              cfg_wen,
    input  logic                              cfg_index,
    input  logic [mvs_pkg::MAG_W-1:0]         cfg_data,
    output mvs_pkg::mvs_word_t                push,
    input  logic                              fifo_full
);
    import mvs_pkg::*;

    logic [MAG_W-1:0]        static_thr_reg;
    logic [MAG_W-1:0]        high_thr_reg;
    logic [MAG_W-1:0]        mag;
    logic signed [DIR_W-1:0] dir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            static_thr_reg <= STATIC_THR_RESET;
            high_thr_reg   <= HIGH_THR_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_STATIC_THR: static_thr_reg <= cfg_data;
                CFG_HIGH_THR:   high_thr_reg   <= cfg_data;
            endcase
        end
    end

    assign mag = s_axis_tdata[MAG_W-1:0];
    assign dir = s_axis_tdata[MAG_W+DIR_W-1:MAG_W];

    assign s_axis_tready = !fifo_full;

    // Bare words carry no vector and close nothing, so they are dropped here.
    always_comb
    begin
        push.valid           = s_axis_tvalid && (s_axis_tuser || s_axis_tlast);
        push.entry.magnitude = mag;
        push.entry.bin       = pick_bin(dir);
        push.entry.is_static = mag < static_thr_reg;
        push.entry.is_high   = mag > high_thr_reg;
        push.entry.is_moving = mag > ONE_Q4;
        push.entry.carries   = s_axis_tuser;
        push.entry.closes    = s_axis_tlast;
    end

endmodule

[hdl/mvs_back.sv]
module mvs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvs_pkg::mvs_word_t                pop,
    output logic                              pop_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import mvs_pkg::*;

    back_state_t        state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TALLY_W-1:0] count_reg, count_next;
    logic [MAG_W-1:0]   max_reg, max_next;
    logic [MAG_W-1:0]   min_reg, min_next;
    logic [TALLY_W-1:0] static_reg, static_next;
    logic [TALLY_W-1:0] high_reg, high_next;
    logic [TALLY_W-1:0] bins_reg [NUM_BINS];
    logic [TALLY_W-1:0] bins_next [NUM_BINS];
    bin_t               sel_reg, sel_next;
    logic [MAG_W-1:0]   avg_reg, avg_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic               div_start;
    logic               div_done;
    logic [MAG_W-1:0]   div_quot;
    logic               load;
    mvs_entry_t         e;

    mvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign e = pop.entry;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        static_next    = static_reg;
        high_next      = high_reg;
        bins_next      = bins_reg;
        sel_next       = sel_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        pop_ready      = 1'b0;
        div_start      = 1'b0;
        load           = 1'b0;

        unique case (state_reg)
            ST_ACC:
            begin
                pop_ready = 1'b1;
                if (pop.valid)
                begin
                    // Once the set is full, further vectors are ignored.
                    if (e.carries && count_reg < TALLY_W'(VEC_CAP))
                    begin
                        if (count_reg == '0)
                        begin
                            max_next = e.magnitude;
                            min_next = e.magnitude;
                        end
                        else
                        begin
                            if (e.magnitude > max_reg) max_next = e.magnitude;
                            if (e.magnitude < min_reg) min_next = e.magnitude;
                        end
                        sum_next   = sum_reg + SUM_W'(e.magnitude);
                        count_next = TALLY_W'(count_reg + 1'b1);
                        if (e.is_static) static_next = TALLY_W'(static_reg + 1'b1);
                        if (e.is_high)   high_next   = TALLY_W'(high_reg + 1'b1);
                        for (int i = 0; i < NUM_BINS; i++)
                        begin
                            if (e.is_moving && e.bin == BIN_W'(i))
                                bins_next[i] = TALLY_W'(bins_reg[i] + 1'b1);
                        end
                    end
                    if (e.closes)
                        state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    avg_next   = (count_reg == '0) ? '0 : div_quot;
                    sel_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                load = !out_valid_reg || m_axis_tready;
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, bins_reg[0], sel_reg, high_reg, static_reg,
                                      min_reg, max_reg, avg_reg};
                    out_last_next  = sel_reg == BIN_W'(NUM_BINS - 1);
                    // Bins shift down so the next word always reads bin zero;
                    // after eight shifts they are all clear.
                    for (int i = 0; i < NUM_BINS - 1; i++)
                        bins_next[i] = bins_reg[i+1];
                    bins_next[NUM_BINS-1] = '0;
                    sel_next = BIN_W'(sel_reg + 1'b1);
                    if (sel_reg == BIN_W'(NUM_BINS - 1))
                    begin
                        sum_next    = '0;
                        count_next  = '0;
                        max_next    = '0;
                        min_next    = '0;
                        static_next = '0;
                        high_next   = '0;
                        state_next  = ST_ACC;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            count_reg     <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            static_reg    <= '0;
            high_reg      <= '0;
            for (int i = 0; i < NUM_BINS; i++)
                bins_reg[i] <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            static_reg    <= static_next;
            high_reg      <= high_next;
            bins_reg      <= bins_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[hdl/motion_vector_statistics_top.sv]
// Flow: a vector word is written into the queue and, once the back end pops it,
// accumulated into the statistics; a closing word then starts the serial divider for the
// average, and results leave one word per cycle while m_axis_tready is high.
// Throughput: one input word per cycle between closes; a close holds the back end
// through the division and the eight result words while the 4-entry queue absorbs input.
// Reset: asynchronous, active low; thresholds return to 16 and 160, all statistics but the average register clear.
module motion_vector_statistics_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: magnitude[15:0], direction[31:16]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mvs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: carries_vector
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    // tdata: average_magnitude[15:0], largest_magnitude[31:16],
    // smallest_magnitude[47:32], static_count[64:48], high_motion_count[81:65],
    // bin_index[84:82], bin_count[101:85], zero fill[103:102]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mvs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_wen,
    input  logic                              cfg_index,
    input  logic [mvs_pkg::MAG_W-1:0]         cfg_data
);
    import mvs_pkg::*;

    mvs_word_t push;
    mvs_word_t pop;
    logic      fifo_full;
    logic      pop_ready;

    mvs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .fifo_full     (fifo_full)
    );

    mvs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (fifo_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    mvs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_ready     (pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
